// ----- rtl/wtrm_pkg.sv -----
package wtrm_pkg;

    // Sizing of the sample history
    localparam int NUM_IFACES = 8;
    localparam int HIST_DEPTH = 1024;
    localparam int IF_W       = $clog2(NUM_IFACES);
    localparam int HIST_W     = $clog2(HIST_DEPTH);
    localparam int FILL_W     = HIST_W + 1;
    localparam int ADDR_W     = IF_W + HIST_W;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 48;
    localparam int RATE_W  = 56;
    localparam int WIN_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int ENTRY_W = TIME_W + 2 * CNT_W;

    // Register indexes
    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_WSHORT = 2'd1;
    localparam logic [1:0] REG_WMID   = 2'd2;
    localparam logic [1:0] REG_WLONG  = 2'd3;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S_SCAN,
        ST_S_WRITE,
        ST_R_SCAN1,
        ST_R_SCAN2,
        ST_R_DIV,
        ST_R_OUT
    } state_t;

    // Divider handshake toward the shared divide unit
    typedef struct packed {
        logic                  start;
        logic [RATE_W-1:0]     dividend;
        logic [TIME_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [RATE_W-1:0]     quotient;
    } div_rsp_t;

endpackage

// ----- rtl/wtrm_div.sv -----
module wtrm_div
    import wtrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(RATE_W + 1);

    logic [RATE_W-1:0]   dvd_reg, dvd_next;
    logic [TIME_W-1:0]   den_reg, den_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [TIME_W:0]     trial;

    // One quotient bit per cycle, restoring division
    always_comb
    begin
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[RATE_W-1]};
        if (req.start)
        begin
            dvd_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(RATE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = TIME_W'(trial - {1'b0, den_reg});
                dvd_next = {dvd_reg[RATE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_W-1:0];
                dvd_next = {dvd_reg[RATE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ----- rtl/windowed_traffic_rate_meter_unit.sv -----
// Traffic rate meter over short, middle and long time windows.
// Input channel (s_*): one beat is either a counter sample (s_tuser = 0)
// or a report request (s_tuser = 1). Samples are stored in the history of
// their interface; a report returns one output beat per active interface,
// in index order, with m_tlast on the final one. Samples give no output.
// Configuration (cfg_*): to be written only while the unit is idle; the
// user must keep to this, the unit does not enforce it. A sample scans
// the filled history slots of its interface (at most 1024), reading one
// slot per cycle from the history memory. A report makes, per interface,
// two memory scans, then six divisions in the shared bit-serial divider,
// then loads the output register.
// One item is worked on at a time; s_tready is high only while idle.
// Reset empties every history (per-interface fill counters clear at once,
// no clearing pass) and loads the register reset values.
// When the receiver stalls, the output register holds its beat and the
// report waits before loading the next one.
module windowed_traffic_rate_meter_unit
    import wtrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // iface[2:0], now_sec[34:3], sent_count[82:35], recv_count[130:83], zero pad
    input  logic [135:0] s_tdata,
    // req_type[0]
    input  logic [0:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // out_iface[2:0], tx short/mid/long, rx short/mid/long, 56 bits each, zero pad
    output logic [343:0] m_tdata,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_data
);

    state_t state_reg, state_next;

    // Configuration
    logic [3:0]       active_reg;
    logic [WIN_W-1:0] wshort_reg, wmid_reg, wlong_reg;
    logic [3:0]       live_n;
    logic [WIN_W-1:0] win [3];

    // Latched request
    logic [IF_W-1:0]   iface_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CNT_W-1:0]  tx_in_reg, rx_in_reg;

    // History memory: {stamp, tx, rx}
    logic [ENTRY_W-1:0] mem [NUM_IFACES*HIST_DEPTH];
    logic [ENTRY_W-1:0] mem_q;
    logic               mem_re, mem_we;
    logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [TIME_W-1:0]  q_stamp;
    logic [CNT_W-1:0]   q_tx, q_rx;

    // Scan control
    logic [FILL_W-1:0] fill_reg [NUM_IFACES];
    logic [IF_W-1:0]   cur_if;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] scan_j_reg;
    logic              rd_vld_reg;
    logic [HIST_W-1:0] rd_j_reg;
    logic              scanning, issue, scan_done;
    logic              stale;
    logic [HIST_W-1:0] wr_idx_reg;
    logic              append_reg;

    // Report working set
    logic [IF_W-1:0]   rep_if_reg;
    logic [2:0]        found_reg;
    logic [TIME_W-1:0] oldest_reg [3];
    logic [CNT_W-1:0]  otx_reg [3];
    logic [CNT_W-1:0]  orx_reg [3];
    logic [CNT_W-1:0]  ctx_reg, crx_reg;
    logic [RATE_W-1:0] rate_reg [6];
    logic [2:0]        k_reg;
    logic              pend_reg;
    logic              last_if;

    // Divider
    div_req_t          dreq;
    div_rsp_t          drsp;
    logic [1:0]        kw;
    logic              kfound;
    logic [CNT_W-1:0]  kcur, kold, kdelta;

    logic              out_load;
    logic              in_acc;

    assign in_acc = s_tvalid && s_tready;

    // Active interface count, clamped to 1..NUM_IFACES
    always_comb
    begin
        if (active_reg == 4'd0)
            live_n = 4'd1;
        else if (active_reg > 4'(NUM_IFACES))
            live_n = 4'(NUM_IFACES);
        else
            live_n = active_reg;
    end

    assign win[0] = wshort_reg;
    assign win[1] = wmid_reg;
    assign win[2] = wlong_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 4'd1;
            wshort_reg <= WIN_W'(60);
            wmid_reg   <= WIN_W'(5 * 60);
            wlong_reg  <= WIN_W'(15 * 60);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ACTIVE: active_reg <= cfg_data[3:0];
                REG_WSHORT: wshort_reg <= cfg_data;
                REG_WMID:   wmid_reg   <= cfg_data;
                REG_WLONG:  wlong_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Memory fields
    assign q_stamp = mem_q[ENTRY_W-1 -: TIME_W];
    assign q_tx    = mem_q[2*CNT_W-1 -: CNT_W];
    assign q_rx    = mem_q[CNT_W-1:0];

    assign cur_if    = (state_reg == ST_S_SCAN || state_reg == ST_S_WRITE) ? iface_reg
                                                                            : rep_if_reg;
    assign fill_cur  = fill_reg[cur_if];
    assign scanning  = (state_reg == ST_S_SCAN) || (state_reg == ST_R_SCAN1)
                       || (state_reg == ST_R_SCAN2);
    assign issue     = scanning && (scan_j_reg < fill_cur);
    assign scan_done = !issue && !rd_vld_reg;
    assign stale     = (q_stamp == '0) ||
                       (({1'b0, q_stamp} + (TIME_W+1)'(wlong_reg)) < {1'b0, now_reg});
    assign last_if   = ({1'b0, rep_if_reg} == 4'(live_n - 4'd1));

    // Divider operand selection for rate k
    always_comb
    begin
        kw     = (k_reg < 3'd3) ? k_reg[1:0] : 2'(k_reg - 3'd3);
        kfound = found_reg[kw];
        kcur   = (k_reg < 3'd3) ? ctx_reg : crx_reg;
        kold   = (k_reg < 3'd3) ? otx_reg[kw] : orx_reg[kw];
        kdelta = (kcur > kold) ? (kcur - kold) : '0;
        if (!kfound || kcur == '0 || kold == '0)
            kdelta = '0;
        dreq.start    = (state_reg == ST_R_DIV) && !pend_reg;
        dreq.dividend = {kdelta, FRAC_W'(0)};
        dreq.divisor  = kfound ? (now_reg - oldest_reg[kw]) : TIME_W'(1);
    end

    wtrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign out_load = (state_reg == ST_R_OUT) && (!m_tvalid || m_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser[0] == REQ_REPORT)
                        state_next = ST_R_SCAN1;
                    else if ({1'b0, s_tdata[2:0]} < live_n && s_tdata[34:3] != '0)
                        state_next = ST_S_SCAN;
                end
            end
            ST_S_SCAN:
            begin
                if (rd_vld_reg && stale)
                    state_next = ST_S_WRITE;
                else if (scan_done)
                    state_next = (fill_cur < FILL_W'(HIST_DEPTH)) ? ST_S_WRITE : ST_IDLE;
            end
            ST_S_WRITE: state_next = ST_IDLE;
            ST_R_SCAN1: if (scan_done) state_next = ST_R_SCAN2;
            ST_R_SCAN2: if (scan_done) state_next = ST_R_DIV;
            ST_R_DIV:   if (drsp.done && k_reg == 3'd5) state_next = ST_R_OUT;
            ST_R_OUT:   if (out_load) state_next = last_if ? ST_IDLE : ST_R_SCAN1;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs toward the memory and the input channel
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        mem_re    = issue;
        mem_raddr = {cur_if, scan_j_reg[HIST_W-1:0]};
        mem_we    = (state_reg == ST_S_WRITE);
        mem_waddr = {iface_reg, wr_idx_reg};
        mem_wdata = {now_reg, tx_in_reg, rx_in_reg};
    end

    // History memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            scan_j_reg <= '0;
            pend_reg   <= 1'b0;
            k_reg      <= '0;
            rep_if_reg <= '0;
            found_reg  <= '0;
            append_reg <= 1'b0;
            m_tvalid   <= 1'b0;
            for (int i = 0; i < NUM_IFACES; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (issue)
                scan_j_reg <= scan_j_reg + 1'b1;

            if (m_tvalid && m_tready && !out_load)
                m_tvalid <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_j_reg <= '0;
                    rep_if_reg <= '0;
                    found_reg  <= '0;
                end
                ST_S_SCAN:
                begin
                    if (rd_vld_reg && stale)
                        append_reg <= 1'b0;
                    else if (scan_done)
                        append_reg <= 1'b1;
                end
                ST_S_WRITE:
                begin
                    if (append_reg)
                        fill_reg[iface_reg] <= fill_reg[iface_reg] + 1'b1;
                end
                ST_R_SCAN1:
                begin
                    if (rd_vld_reg && q_stamp != '0 && q_stamp < now_reg)
                    begin
                        for (int w = 0; w < 3; w++)
                        begin
                            if (({1'b0, q_stamp} + (TIME_W+1)'(win[w])) >= {1'b0, now_reg}
                                && (!found_reg[w] || q_stamp < oldest_reg[w]))
                                found_reg[w] <= 1'b1;
                        end
                    end
                    if (scan_done)
                        scan_j_reg <= '0;
                end
                ST_R_SCAN2:
                begin
                    k_reg    <= '0;
                    pend_reg <= 1'b0;
                end
                ST_R_DIV:
                begin
                    if (dreq.start)
                        pend_reg <= 1'b1;
                    if (drsp.done)
                    begin
                        pend_reg <= 1'b0;
                        k_reg    <= k_reg + 1'b1;
                    end
                end
                ST_R_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid   <= 1'b1;
                        rep_if_reg <= rep_if_reg + 1'b1;
                        scan_j_reg <= '0;
                        found_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_j_reg <= scan_j_reg[HIST_W-1:0];
        if (in_acc)
        begin
            iface_reg <= s_tdata[2:0];
            now_reg   <= s_tdata[34:3];
            tx_in_reg <= s_tdata[82:35];
            rx_in_reg <= s_tdata[130:83];
        end

        // Sample slot choice: first stale slot, else append if the history is not full
        if (state_reg == ST_S_SCAN)
        begin
            if (rd_vld_reg && stale)
                wr_idx_reg <= rd_j_reg;
            else if (scan_done)
                wr_idx_reg <= fill_cur[HIST_W-1:0];
        end

        // Oldest stamp per window
        if (state_reg == ST_R_SCAN1 && rd_vld_reg && q_stamp != '0 && q_stamp < now_reg)
        begin
            for (int w = 0; w < 3; w++)
            begin
                if (({1'b0, q_stamp} + (TIME_W+1)'(win[w])) >= {1'b0, now_reg}
                    && (!found_reg[w] || q_stamp < oldest_reg[w]))
                    oldest_reg[w] <= q_stamp;
            end
        end

        // Counters of the current and window samples, last match wins
        if (state_reg == ST_R_SCAN1)
        begin
            ctx_reg <= '0;
            crx_reg <= '0;
            for (int w = 0; w < 3; w++)
            begin
                otx_reg[w] <= '0;
                orx_reg[w] <= '0;
            end
        end
        else if (state_reg == ST_R_SCAN2 && rd_vld_reg && q_stamp != '0)
        begin
            if (q_stamp == now_reg)
            begin
                ctx_reg <= q_tx;
                crx_reg <= q_rx;
            end
            for (int w = 0; w < 3; w++)
            begin
                if (found_reg[w] && q_stamp == oldest_reg[w])
                begin
                    otx_reg[w] <= q_tx;
                    orx_reg[w] <= q_rx;
                end
            end
        end

        if (state_reg == ST_R_DIV && drsp.done)
            rate_reg[k_reg] <= drsp.quotient;

        // Output beat
        if (out_load)
        begin
            m_tdata <= {5'd0, rate_reg[5], rate_reg[4], rate_reg[3],
                        rate_reg[2], rate_reg[1], rate_reg[0], rep_if_reg};
            m_tlast <= last_if;
        end
    end

endmodule

// ----- tb/sv/windowed_traffic_rate_meter_unit_tb.sv -----
`timescale 1ns / 100ps

module windowed_traffic_rate_meter_unit_tb
    import wtrm_pkg::*;
();

    localparam int        SETTLE_CYC = 1100;
    localparam longint    MASK56     = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [47:0] CNT_MAX  = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic              req;
        logic [2:0]        ifc;
        logic [31:0]       now;
        logic [47:0]       tx;
        logic [47:0]       rx;
    } meter_req_t;

    // rate order: tx short/mid/long, rx short/mid/long
    typedef struct packed {
        logic [2:0]        ifc;
        logic [5:0][55:0]  rate;
        logic              last;
    } meter_line_t;

    typedef struct packed {
        meter_req_t        it;
        logic              typed;
        meter_line_t       line;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic [135:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tvalid;
    logic         s_tready;
    logic [343:0] m_tdata;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [15:0]  cfg_data;

    windowed_traffic_rate_meter_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Shadow of the history and registers
    logic [31:0] hist_stamp [NUM_IFACES][HIST_DEPTH];
    logic [47:0] hist_tx    [NUM_IFACES][HIST_DEPTH];
    logic [47:0] hist_rx    [NUM_IFACES][HIST_DEPTH];
    logic [3:0]  sh_active;
    logic [15:0] sh_win [3];

    meter_line_t pending_lines[$];
    int          err_cnt;
    int          src_idle_pct;
    int          dst_stall_pct;
    logic        long_hold_req;
    logic        long_hold_done;

    // Working state of the random generator
    logic [31:0] clock_sec;
    logic [47:0] acc_tx [NUM_IFACES];
    logic [47:0] acc_rx [NUM_IFACES];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int live_ifaces();
        int n;
        n = sh_active;
        if (n < 1) n = 1;
        if (n > NUM_IFACES) n = NUM_IFACES;
        return n;
    endfunction

    function automatic logic [55:0] window_rate(logic [47:0] cur, logic [47:0] old,
                                                logic [31:0] dt);
        longint unsigned delta;
        if (cur == 0 || old == 0 || dt == 0)
            return '0;
        delta = (cur > old) ? longint'(cur - old) : 0;
        return 56'(((delta << 8) / longint'(dt)) & MASK56);
    endfunction

    // Store a sample into the first free or stale slot
    function automatic void store_sample(meter_req_t it);
        logic [32:0] aged;
        if (it.ifc >= live_ifaces() || it.now == 0)
            return;
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            aged = {1'b0, hist_stamp[it.ifc][j]} + sh_win[2];
            if (hist_stamp[it.ifc][j] == 0 || aged < {1'b0, it.now})
            begin
                hist_stamp[it.ifc][j] = it.now;
                hist_tx[it.ifc][j]    = it.tx;
                hist_rx[it.ifc][j]    = it.rx;
                return;
            end
        end
    endfunction

    // Compute one report line for an interface
    function automatic meter_line_t rate_line(int ifc, logic [31:0] now, logic last);
        meter_line_t ln;
        logic [31:0] oldest [3];
        logic        found  [3];
        logic [47:0] otx [3];
        logic [47:0] orx [3];
        logic [47:0] ctx;
        logic [47:0] crx;
        logic [31:0] s;
        ctx = '0;
        crx = '0;
        for (int w = 0; w < 3; w++)
        begin
            oldest[w] = '0; found[w] = 1'b0; otx[w] = '0; orx[w] = '0;
        end
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            s = hist_stamp[ifc][j];
            if (s != 0 && s < now)
                for (int w = 0; w < 3; w++)
                    if ({1'b0, s} + sh_win[w] >= {1'b0, now} && (!found[w] || s < oldest[w]))
                    begin
                        oldest[w] = s;
                        found[w]  = 1'b1;
                    end
        end
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            s = hist_stamp[ifc][j];
            if (s != 0)
            begin
                if (s == now)
                begin
                    ctx = hist_tx[ifc][j];
                    crx = hist_rx[ifc][j];
                end
                for (int w = 0; w < 3; w++)
                    if (found[w] && s == oldest[w])
                    begin
                        otx[w] = hist_tx[ifc][j];
                        orx[w] = hist_rx[ifc][j];
                    end
            end
        end
        ln.ifc  = ifc[2:0];
        ln.last = last;
        for (int w = 0; w < 3; w++)
        begin
            ln.rate[w]     = found[w] ? window_rate(ctx, otx[w], now - oldest[w]) : '0;
            ln.rate[3 + w] = found[w] ? window_rate(crx, orx[w], now - oldest[w]) : '0;
        end
        return ln;
    endfunction

    function automatic void predict_meter(meter_req_t it);
        int n;
        if (it.req == REQ_SAMPLE)
        begin
            store_sample(it);
            return;
        end
        n = live_ifaces();
        for (int i = 0; i < n; i++)
            pending_lines.push_back(rate_line(i, it.now, i == n - 1));
    endfunction

    // Offer one beat; valid stays high until the next gap or the end
    task automatic send_beat(meter_req_t it, logic typed, meter_line_t line);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tdata  = {5'd0, it.rx, it.tx, it.now, it.ifc};
        s_tuser  = it.req;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        if (typed && it.req == REQ_REPORT)
            pending_lines.push_back(line);
        else
            predict_meter(it);
        @(negedge clk);
    endtask

    // Wait for the unit to drain, then a margin for a sample still in flight
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_lines.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] val);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = val;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (addr)
            REG_ACTIVE: sh_active = val[3:0];
            REG_WSHORT: sh_win[0] = val;
            REG_WMID:   sh_win[1] = val;
            default:    sh_win[2] = val;
        endcase
    endtask

    task automatic set_regs(logic [15:0] act, logic [15:0] ws, logic [15:0] wm,
                            logic [15:0] wl);
        wait_drained();
        write_reg(REG_ACTIVE, act);
        write_reg(REG_WSHORT, ws);
        write_reg(REG_WMID, wm);
        write_reg(REG_WLONG, wl);
    endtask

    function automatic logic [47:0] rand_cnt();
        return 48'({$urandom(), $urandom()} & CNT_MAX);
    endfunction

    // Random item: mostly advancing samples, some reports, some noise
    function automatic meter_req_t rand_item();
        meter_req_t it;
        int         r;
        it.req = ($urandom_range(99) < 18) ? REQ_REPORT : REQ_SAMPLE;
        it.ifc = ($urandom_range(9) < 8) ? 3'($urandom_range(live_ifaces() - 1))
                                         : 3'($urandom_range(7));
        if (it.req == REQ_SAMPLE)
            clock_sec = clock_sec + $urandom_range(0, 20);
        it.now = clock_sec;
        r = $urandom_range(99);
        if (r < 3)
            it.now = '0;
        else if (r < 6)
            it.now = $urandom();
        acc_tx[it.ifc] = (acc_tx[it.ifc] + $urandom_range(0, 100000)) & CNT_MAX;
        acc_rx[it.ifc] = (acc_rx[it.ifc] + $urandom_range(0, 100000)) & CNT_MAX;
        it.tx = acc_tx[it.ifc];
        it.rx = acc_rx[it.ifc];
        r = $urandom_range(99);
        if (r < 10)
        begin
            it.tx = rand_cnt();
            it.rx = rand_cnt();
        end
        else if (r < 15)
        begin
            it.tx = '0;
            it.rx = ($urandom_range(1)) ? '0 : CNT_MAX;
        end
        return it;
    endfunction

    task automatic run_random(int count, int src_pct, int dst_pct);
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        repeat (count) send_beat(rand_item(), 1'b0, '0);
    endtask

    // Build a directed row
    function automatic dir_row_t row(logic req, logic [2:0] ifc, logic [31:0] now,
                                     logic [47:0] tx, logic [47:0] rx, logic typed,
                                     logic [55:0] tx_rate, logic [55:0] rx_rate);
        dir_row_t d;
        d.it    = '{req, ifc, now, tx, rx};
        d.typed = typed;
        d.line.ifc  = 3'd0;
        d.line.last = 1'b1;
        for (int w = 0; w < 3; w++)
        begin
            d.line.rate[w]     = tx_rate;
            d.line.rate[3 + w] = rx_rate;
        end
        return d;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        static int hold_cnt = 0;
        if (!rst_n)
        begin
            m_tready       <= 1'b0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= 3000)
                long_hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        meter_line_t got;
        meter_line_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ifc  = m_tdata[2:0];
            got.last = m_tlast;
            for (int k = 0; k < 6; k++)
                got.rate[k] = m_tdata[3 + 56 * k +: 56];
            if (pending_lines.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected report beat: iface %0d last %0b", got.ifc, got.last);
            end
            else
            begin
                want = pending_lines.pop_front();
                if (got != want)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("report beat mismatch: iface exp %0d got %0d, last exp %0b got %0b",
                                 want.ifc, got.ifc, want.last, got.last);
                        for (int k = 0; k < 6; k++)
                            if (got.rate[k] != want.rate[k])
                                $display("  rate %0d: exp %0h got %0h", k, want.rate[k],
                                         got.rate[k]);
                    end
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #40ms;
        $display("windowed_traffic_rate_meter_unit_tb: done, errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        dir_row_t    dir_rows[$];
        meter_req_t  it;
        logic [31:0] fill_t;

        rst_n          = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        s_tvalid       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_data       = '0;
        err_cnt        = 0;
        src_idle_pct   = 0;
        dst_stall_pct  = 0;
        long_hold_req  = 1'b0;
        clock_sec      = 32'd2000;
        sh_active      = 4'd1;
        sh_win[0]      = 16'd60;
        sh_win[1]      = 16'd300;
        sh_win[2]      = 16'd900;
        for (int i = 0; i < NUM_IFACES; i++)
        begin
            acc_tx[i] = 48'd1;
            acc_rx[i] = 48'd1;
            for (int j = 0; j < HIST_DEPTH; j++)
            begin
                hist_stamp[i][j] = '0;
                hist_tx[i][j]    = '0;
                hist_rx[i][j]    = '0;
            end
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset register values
        dir_rows.push_back(row(REQ_REPORT, 3'd5, 32'd0, '0, '0, 1'b1, '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd0, 32'd0, 48'd7, 48'd7, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd1, 32'd100, 48'd7, 48'd7, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd0, 32'd1000, 48'd1000, 48'd0, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd0, 32'd1010, 48'd3560, 48'd5, 1'b0, '0, '0));
        // 2560 counts over 10 s: 256 per second, with 8 fraction bits
        dir_rows.push_back(row(REQ_REPORT, 3'd0, 32'd1010, '0, '0, 1'b1, 56'd65536, '0));
        // counter fell back: clamps to zero; old receive counter zero
        dir_rows.push_back(row(REQ_SAMPLE, 3'd0, 32'd1020, 48'd500, CNT_MAX, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_REPORT, 3'd0, 32'd1020, '0, '0, 1'b1, '0, '0));
        dir_rows.push_back(row(REQ_REPORT, 3'd7, 32'd1005, '0, '0, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_REPORT, 3'd0, 32'd999, '0, '0, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd0, 32'd1070, CNT_MAX, CNT_MAX, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_REPORT, 3'd0, 32'd1070, '0, '0, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_REPORT, 3'd0, 32'd1080, '0, '0, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd7, 32'hFFFF_FFFF, CNT_MAX, CNT_MAX, 1'b0,
                               '0, '0));
        dir_rows.push_back(row(REQ_SAMPLE, 3'd0, 32'hFFFF_FFFF, 48'd1, 48'd1, 1'b0, '0, '0));
        dir_rows.push_back(row(REQ_REPORT, 3'd0, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0));
        foreach (dir_rows[k])
            send_beat(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].line);

        // Random phases over several register settings
        set_regs(16'd8, 16'd1, 16'd50, 16'd200);
        run_random(24, 0, 0);
        set_regs(16'd15, 16'd0, 16'd65535, 16'd65535);
        run_random(24, 48, 0);
        set_regs(16'd3, 16'd20, 16'd100, 16'd300);
        // long receiver hold-off while items keep coming
        long_hold_req = 1'b1;
        it = rand_item();
        it.req = REQ_REPORT;
        send_beat(it, 1'b0, '0);
        run_random(24, 0, 48);
        long_hold_req = 1'b0;
        set_regs(16'd8, 16'd60, 16'd300, 16'd900);
        run_random(24, 18, 18);
        set_regs(16'd0, 16'd65535, 16'd0, 16'd1);
        run_random(20, 0, 0);

        // Several samples sharing one stamp, then age them out
        set_regs(16'd1, 16'd60, 16'd300, 16'd65535);
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        fill_t = clock_sec + 32'd10;
        for (int k = 0; k < 4; k++)
            send_beat('{REQ_SAMPLE, 3'd0, fill_t, 48'(k + 1), 48'(2 * k + 1)}, 1'b0, '0);
        send_beat('{REQ_REPORT, 3'd0, fill_t, 48'd0, 48'd0}, 1'b0, '0);
        set_regs(16'd1, 16'd60, 16'd300, 16'd1);
        send_beat('{REQ_SAMPLE, 3'd0, fill_t + 32'd5, 48'd9000, 48'd9000}, 1'b0, '0);
        send_beat('{REQ_REPORT, 3'd0, fill_t + 32'd5, 48'd0, 48'd0}, 1'b0, '0);

        // Drain and finish
        s_tvalid = 1'b0;
        while (pending_lines.size() != 0) @(negedge clk);
        repeat (2000) @(negedge clk);
        if (err_cnt == 0 && pending_lines.size() == 0)
            $display("windowed_traffic_rate_meter_unit_tb: done, clean");
        else
            $display("windowed_traffic_rate_meter_unit_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wtrm_pkg.sv
rtl/wtrm_div.sv
rtl/windowed_traffic_rate_meter_unit.sv
tb/sv/windowed_traffic_rate_meter_unit_tb.sv
